// ===== src/usf_pkg.sv =====
// usf_pkg: shared types, constants and the built-in server table of the
// UDP sequencer fan-out block. No dependencies.
`timescale 1ns / 1ps

package usf_pkg;

  // Number of server entries (1..8).
  localparam int NUM_SERVERS = 5;
  localparam int IDX_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int NUM_BUILTIN = 5;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam logic [15:0] SEQ_PORT_RST = 16'd7072;
  localparam logic [31:0] SEQ_IP_RST   = 32'hC0A8_210B;
  localparam logic [47:0] SEQ_MAC_RST  = 48'h0800_27B2_B1F9;

  localparam logic CMD_PACKET      = 1'b0;
  localparam logic CMD_TABLE_WRITE = 1'b1;

  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_COPY = 1'b1;

  typedef enum logic [1:0] {
    CFG_SEQ_PORT = 2'd0,
    CFG_SEQ_IP   = 2'd1,
    CFG_SEQ_MAC  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] port;
  } server_t;

  // Table write request from the issue stage to the table memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    server_t          data;
  } tbl_wr_t;

  // One result slot handed from the issue stage to the rewrite stage.
  typedef struct packed {
    logic             match;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic [19:0]      base_sum;
    logic [31:0]      seq;
  } slot_t;

  typedef struct packed {
    logic        verdict;
    logic [2:0]  copy_index;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] dest_ip;
    logic [31:0] source_ip;
    logic [15:0] dest_port;
    logic [15:0] ip_checksum;
    logic [31:0] sequence_res;
    logic        last_copy;
  } res_t;

  // Reset contents of the server table; entries past the built-in ones are zero.
  function automatic server_t builtin_entry(input logic [IDX_W-1:0] idx);
    int      k;
    server_t e;
    k = int'(idx);
    case (k)
      0:       e = '{mac: 48'h0800_2767_4F20, ip: 32'hC0A8_210A, port: 16'd7073};
      1:       e = '{mac: 48'h9C2D_CD3F_67A4, ip: 32'hC0A8_32E0, port: 16'd8073};
      2:       e = '{mac: 48'h9C2D_CD3F_67A4, ip: 32'hC0A8_32E0, port: 16'd9073};
      3:       e = '{mac: 48'h9C2D_CD48_B104, ip: 32'hC0A8_32D5, port: 16'd10073};
      4:       e = '{mac: 48'h9C2D_CD48_B104, ip: 32'hC0A8_32D5, port: 16'd11073};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ===== src/usf_table_mem.sv =====
// usf_table_mem: server table, one write and one registered read port.
// Depends on usf_pkg. Unwritten entries read as the built-in servers.
`timescale 1ns / 1ps

module usf_table_mem (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  usf_pkg::tbl_wr_t        wr_i,
  input  logic                    rd_en_i,
  input  logic [usf_pkg::IDX_W-1:0] rd_addr_i,
  output usf_pkg::server_t        rd_data_o
);

  usf_pkg::server_t                 mem_q [usf_pkg::NUM_SERVERS];
  logic [usf_pkg::NUM_SERVERS-1:0]  valid_q;
  usf_pkg::server_t                 rd_q;
  logic                             rd_hit_q;
  logic [usf_pkg::IDX_W-1:0]        rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits and read tag; read sees the pre-write value on a same-edge write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= valid_q[rd_addr_i];
        rd_idx_q <= rd_addr_i;
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_q : usf_pkg::builtin_entry(rd_idx_q);

endmodule

// ===== src/usf_issue.sv =====
// usf_issue: input acceptance, match decode, sequence counter and read issue.
// Depends on usf_pkg. Emits one slot per result and drives the table ports.
`timescale 1ns / 1ps

module usf_issue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [15:0]               ether_type_i,
  input  logic [7:0]                ip_protocol_i,
  input  logic [15:0]               udp_dest_port_i,
  input  logic                      header_complete_i,
  input  logic [63:0]               ip_head_words_i,
  input  logic [7:0]                ip_ttl_i,
  input  logic [2:0]                entry_index_i,
  input  logic [15:0]               entry_port_i,
  input  logic [31:0]               entry_ip_i,
  input  logic [47:0]               entry_mac_i,
  input  logic [15:0]               seq_port_i,
  input  logic [31:0]               seq_ip_i,
  output usf_pkg::tbl_wr_t          wr_o,
  output logic                      rd_en_o,
  output logic [usf_pkg::IDX_W-1:0] rd_addr_o,
  output logic                      slot_valid_o,
  output usf_pkg::slot_t            slot_o,
  input  logic                      slot_ready_i
);

  localparam logic [usf_pkg::IDX_W-1:0] LastIdx = usf_pkg::IDX_W'(usf_pkg::NUM_SERVERS - 1);

  logic                      busy_q, busy_d;
  logic                      match_q, match_d;
  logic [usf_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [19:0]               base_q, base_d;
  logic [31:0]               seq_q, seq_d;
  logic [31:0]               seq_cnt_q, seq_cnt_d;

  logic        fire, is_last, accept, pkt_accept, match_in;
  logic [19:0] base_in;

  assign fire    = busy_q & slot_ready_i;
  assign is_last = !match_q || (idx_q == LastIdx);

  // Next item may enter on the cycle the last slot of the current one leaves.
  assign in_ready_o = !busy_q || (fire && is_last);
  assign accept     = in_valid_i & in_ready_o;
  assign pkt_accept = accept & (command_i == usf_pkg::CMD_PACKET);

  assign match_in = header_complete_i && (ether_type_i == usf_pkg::ETHERTYPE_IPV4) &&
                    (ip_protocol_i == usf_pkg::PROTO_UDP) && (udp_dest_port_i == seq_port_i);

  // Part of the header sum that does not depend on the server.
  assign base_in = 20'(ip_head_words_i[15:0]) + 20'(ip_head_words_i[31:16]) +
                   20'(ip_head_words_i[47:32]) + 20'(ip_head_words_i[63:48]) +
                   20'({ip_ttl_i, usf_pkg::PROTO_UDP}) +
                   20'(seq_ip_i[31:16]) + 20'(seq_ip_i[15:0]);

  always_comb begin
    busy_d    = busy_q;
    match_d   = match_q;
    idx_d     = idx_q;
    base_d    = base_q;
    seq_d     = seq_q;
    seq_cnt_d = seq_cnt_q;
    if (fire) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + usf_pkg::IDX_W'(1);
      end
    end
    if (pkt_accept) begin
      busy_d  = 1'b1;
      match_d = match_in;
      idx_d   = '0;
      base_d  = base_in;
      if (match_in) begin
        seq_cnt_d = seq_cnt_q + 32'd1;
        seq_d     = seq_cnt_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      match_q   <= 1'b0;
      idx_q     <= '0;
      seq_cnt_q <= '0;
    end else begin
      busy_q    <= busy_d;
      match_q   <= match_d;
      idx_q     <= idx_d;
      seq_cnt_q <= seq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    seq_q  <= seq_d;
  end

  assign wr_o.en   = accept && (command_i == usf_pkg::CMD_TABLE_WRITE) &&
                     (int'(entry_index_i) < usf_pkg::NUM_SERVERS);
  assign wr_o.addr = usf_pkg::IDX_W'(entry_index_i);
  assign wr_o.data = '{mac: entry_mac_i, ip: entry_ip_i, port: entry_port_i};

  assign rd_en_o   = fire & match_q;
  assign rd_addr_o = idx_q;

  assign slot_valid_o   = busy_q;
  assign slot_o.match    = match_q;
  assign slot_o.idx      = idx_q;
  assign slot_o.last     = is_last;
  assign slot_o.base_sum = base_q;
  assign slot_o.seq      = seq_q;

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_accept && match_in) |=> (seq_cnt_q == $past(seq_cnt_q) + 32'd1))
    else $error("sequence counter did not advance by one on a match");

  a_seq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pkt_accept && match_in) |=> $stable(seq_cnt_q))
    else $error("sequence counter moved without a match");

  a_wr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (!busy_q || (fire && is_last)))
    else $error("table write overtook a fan-out in progress");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= LastIdx))
    else $error("server index past the table");

endmodule

// ===== src/usf_rewrite.sv =====
// usf_rewrite: joins a slot with its table entry, builds the checksum and
// holds the result register. Depends on usf_pkg.
`timescale 1ns / 1ps

module usf_rewrite (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             slot_valid_i,
  input  usf_pkg::slot_t   slot_i,
  output logic             slot_ready_o,
  input  usf_pkg::server_t entry_i,
  input  logic [31:0]      seq_ip_i,
  input  logic [47:0]      seq_mac_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output usf_pkg::res_t    res_o
);

  logic           b_valid_q, b_valid_d;
  usf_pkg::slot_t b_slot_q;
  logic           out_valid_q, out_valid_d;
  usf_pkg::res_t  res_q, res_d;
  logic           b_adv;
  logic [19:0]    s0;
  logic [16:0]    s1, s2;

  assign b_adv        = b_valid_q & (!out_valid_q | out_ready_i);
  assign slot_ready_o = !b_valid_q | b_adv;

  // End-around fold of the header sum, then invert.
  assign s0 = b_slot_q.base_sum + 20'(entry_i.ip[31:16]) + 20'(entry_i.ip[15:0]);
  assign s1 = 17'(s0[15:0]) + 17'(s0[19:16]);
  assign s2 = 17'(s1[15:0]) + 17'(s1[16]);

  always_comb begin
    res_d = '0;
    if (b_slot_q.match) begin
      res_d.verdict      = usf_pkg::VERDICT_COPY;
      res_d.copy_index   = 3'(b_slot_q.idx);
      res_d.dest_mac     = entry_i.mac;
      res_d.source_mac   = seq_mac_i;
      res_d.dest_ip      = entry_i.ip;
      res_d.source_ip    = seq_ip_i;
      res_d.dest_port    = entry_i.port;
      res_d.ip_checksum  = ~s2[15:0];
      res_d.sequence_res = b_slot_q.seq;
    end else begin
      res_d.verdict = usf_pkg::VERDICT_PASS;
    end
    res_d.last_copy = b_slot_q.last;
  end

  always_comb begin
    b_valid_d = b_valid_q;
    if (b_adv) begin
      b_valid_d = 1'b0;
    end
    if (slot_valid_i && slot_ready_o) begin
      b_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (b_adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_valid_i && slot_ready_o) begin
      b_slot_q <= slot_i;
    end
    if (b_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/udp_sequencer_fanout.sv =====
// udp_sequencer_fanout: top level of the UDP sequencer fan-out block.
// Depends on usf_pkg, usf_table_mem, usf_issue and usf_rewrite.
`timescale 1ns / 1ps

// Usage
//  Input channel (in_valid_i/in_ready_o): one transaction is either a parsed
//  packet header (command_i = 0) or a server table write (command_i = 1).
//  Output channel (out_valid_o/out_ready_i): one transaction per result.
//  A matching packet (complete, IPv4, UDP, dest port = seq_port_q) bumps
//  the 32-bit sequence counter and yields NUM_SERVERS rewritten copies, one
//  per cycle unless stalled, last_copy set on the final one. Any other
//  packet yields a single pass result. A table write yields nothing.
//  Throughput: a matching packet holds the input while the single read port
//  of the server table reads its entries, one per cycle unless stalled; a
//  pass packet holds it until its slot is taken; a table write, not at all.
//  The next transaction is taken in the cycle the packet's last table read is issued.
//  Result path: on accept the issue state loads, then the table read
//  register, then the result register, which presents the first result.
//  Reset: sequence counter 0, config registers at their defaults, table
//  entries read as the built-in servers until written. No clearing pass.
//  Stall: the result register holds while out_ready_i is low; the stall
//  walks back through the pipeline and drops in_ready_o.
//  Config port: write only while the block is idle.

module udp_sequencer_fanout (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [15:0] ether_type_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [15:0] udp_dest_port_i,
  input  logic        header_complete_i,
  input  logic [63:0] ip_head_words_i,
  input  logic [7:0]  ip_ttl_i,
  input  logic [2:0]  entry_index_i,
  input  logic [15:0] entry_port_i,
  input  logic [31:0] entry_ip_i,
  input  logic [47:0] entry_mac_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        verdict_o,
  output logic [2:0]  copy_index_o,
  output logic [47:0] dest_mac_o,
  output logic [47:0] source_mac_o,
  output logic [31:0] dest_ip_o,
  output logic [31:0] source_ip_o,
  output logic [15:0] dest_port_o,
  output logic [15:0] ip_checksum_o,
  output logic [31:0] sequence_res_o,
  output logic        last_copy_o
);

  logic [15:0] seq_port_q;
  logic [31:0] seq_ip_q;
  logic [47:0] seq_mac_q;

  usf_pkg::tbl_wr_t          tbl_wr;
  logic                      rd_en;
  logic [usf_pkg::IDX_W-1:0] rd_addr;
  usf_pkg::server_t          rd_entry;
  logic                      slot_valid, slot_ready;
  usf_pkg::slot_t            slot;
  usf_pkg::res_t             res;

  // Config registers; indices outside the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_port_q <= usf_pkg::SEQ_PORT_RST;
      seq_ip_q   <= usf_pkg::SEQ_IP_RST;
      seq_mac_q  <= usf_pkg::SEQ_MAC_RST;
    end else if (cfg_we_i) begin
      unique case (usf_pkg::cfg_reg_e'(cfg_index_i))
        usf_pkg::CFG_SEQ_PORT: seq_port_q <= cfg_data_i[15:0];
        usf_pkg::CFG_SEQ_IP:   seq_ip_q   <= cfg_data_i[31:0];
        usf_pkg::CFG_SEQ_MAC:  seq_mac_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  usf_issue u_issue (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .ether_type_i      (ether_type_i),
    .ip_protocol_i     (ip_protocol_i),
    .udp_dest_port_i   (udp_dest_port_i),
    .header_complete_i (header_complete_i),
    .ip_head_words_i   (ip_head_words_i),
    .ip_ttl_i          (ip_ttl_i),
    .entry_index_i     (entry_index_i),
    .entry_port_i      (entry_port_i),
    .entry_ip_i        (entry_ip_i),
    .entry_mac_i       (entry_mac_i),
    .seq_port_i        (seq_port_q),
    .seq_ip_i          (seq_ip_q),
    .wr_o              (tbl_wr),
    .rd_en_o           (rd_en),
    .rd_addr_o         (rd_addr),
    .slot_valid_o      (slot_valid),
    .slot_o            (slot),
    .slot_ready_i      (slot_ready)
  );

  // Server table: read issued with the slot; the registered read data lines up with it in the rewrite slot buffer.
  usf_table_mem u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  usf_rewrite u_rewrite (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .slot_valid_i (slot_valid),
    .slot_i       (slot),
    .slot_ready_o (slot_ready),
    .entry_i      (rd_entry),
    .seq_ip_i     (seq_ip_q),
    .seq_mac_i    (seq_mac_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign verdict_o      = res.verdict;
  assign copy_index_o   = res.copy_index;
  assign dest_mac_o     = res.dest_mac;
  assign source_mac_o   = res.source_mac;
  assign dest_ip_o      = res.dest_ip;
  assign source_ip_o    = res.source_ip;
  assign dest_port_o    = res.dest_port;
  assign ip_checksum_o  = res.ip_checksum;
  assign sequence_res_o = res.sequence_res;
  assign last_copy_o    = res.last_copy;

endmodule

// ===== test/tb_udp_sequencer_fanout.sv =====
// tb_udp_sequencer_fanout: self-checking testbench for the UDP sequencer fan-out block.
// Drives header and table-write transactions and checks every result against a
// local predictor. Depends on usf_pkg and udp_sequencer_fanout.
`timescale 1ns / 1ps

module tb_udp_sequencer_fanout;

  // Cycles to let pass after the last result before touching config or ending:
  // three pipeline stages plus margin for a table write still in flight.
  localparam int LAT_CYCLES = 8;

  // One input transaction as queued for the driver.
  typedef struct packed {
    logic        command;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] udp_dest_port;
    logic        header_complete;
    logic [63:0] ip_head_words;
    logic [7:0]  ip_ttl;
    logic [2:0]  entry_index;
    logic [15:0] entry_port;
    logic [31:0] entry_ip;
    logic [47:0] entry_mac;
  } hdr_item_t;

  // DUT inputs, all known from time zero.
  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_we_i          = 1'b0;
  logic [1:0]  cfg_index_i       = 2'd0;
  logic [47:0] cfg_data_i        = '0;
  logic        in_valid_i        = 1'b0;
  logic        command_i         = 1'b0;
  logic [15:0] ether_type_i      = '0;
  logic [7:0]  ip_protocol_i     = '0;
  logic [15:0] udp_dest_port_i   = '0;
  logic        header_complete_i = 1'b0;
  logic [63:0] ip_head_words_i   = '0;
  logic [7:0]  ip_ttl_i          = '0;
  logic [2:0]  entry_index_i     = '0;
  logic [15:0] entry_port_i      = '0;
  logic [31:0] entry_ip_i        = '0;
  logic [47:0] entry_mac_i       = '0;
  logic        out_ready_i       = 1'b0;

  // DUT outputs
  logic        in_ready_o;
  logic        out_valid_o;
  logic        verdict_o;
  logic [2:0]  copy_index_o;
  logic [47:0] dest_mac_o;
  logic [47:0] source_mac_o;
  logic [31:0] dest_ip_o;
  logic [31:0] source_ip_o;
  logic [15:0] dest_port_o;
  logic [15:0] ip_checksum_o;
  logic [31:0] sequence_res_o;
  logic        last_copy_o;

  // Predictor state: config shadow, sequence counter, server table.
  logic [15:0]      seq_port_m;
  logic [31:0]      seq_ip_m;
  logic [47:0]      seq_mac_m;
  logic [31:0]      seq_count_m;
  usf_pkg::server_t servers_m [usf_pkg::NUM_SERVERS];

  hdr_item_t     pending_items[$];    // transactions waiting for the driver
  usf_pkg::res_t expected_copies[$];  // predicted results, oldest first
  hdr_item_t     cur_item;            // transaction currently on the input port

  int mismatches = 0;
  int send_gap   = 0;   // remaining idle cycles on the input side
  int stall_left = 0;   // remaining stall cycles on the output side
  bit idle_en    = 1'b0;

  udp_sequencer_fanout uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .ether_type_i      (ether_type_i),
    .ip_protocol_i     (ip_protocol_i),
    .udp_dest_port_i   (udp_dest_port_i),
    .header_complete_i (header_complete_i),
    .ip_head_words_i   (ip_head_words_i),
    .ip_ttl_i          (ip_ttl_i),
    .entry_index_i     (entry_index_i),
    .entry_port_i      (entry_port_i),
    .entry_ip_i        (entry_ip_i),
    .entry_mac_i       (entry_mac_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .verdict_o         (verdict_o),
    .copy_index_o      (copy_index_o),
    .dest_mac_o        (dest_mac_o),
    .source_mac_o      (source_mac_o),
    .dest_ip_o         (dest_ip_o),
    .source_ip_o       (source_ip_o),
    .dest_port_o       (dest_port_o),
    .ip_checksum_o     (ip_checksum_o),
    .sequence_res_o    (sequence_res_o),
    .last_copy_o       (last_copy_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // IPv4 header checksum: ones' complement sum of the ten header words with the
  // checksum word zero, folded end-around twice, then inverted.
  function automatic logic [15:0] ipv4_hdr_csum(input logic [63:0] head, input logic [7:0] ttl,
                                                 input logic [31:0] sip, input logic [31:0] dip);
    logic [31:0] acc;
    acc = 32'(head[15:0]) + 32'(head[31:16]) + 32'(head[47:32]) + 32'(head[63:48]);
    acc = acc + 32'({ttl, usf_pkg::PROTO_UDP});
    acc = acc + 32'(sip[31:16]) + 32'(sip[15:0]) + 32'(dip[31:16]) + 32'(dip[15:0]);
    acc = 32'(acc[15:0]) + 32'(acc[31:16]);
    acc = 32'(acc[15:0]) + 32'(acc[31:16]);
    return ~acc[15:0];
  endfunction

  task automatic reset_model();
    int i;
    seq_port_m  = usf_pkg::SEQ_PORT_RST;
    seq_ip_m    = usf_pkg::SEQ_IP_RST;
    seq_mac_m   = usf_pkg::SEQ_MAC_RST;
    seq_count_m = '0;
    for (i = 0; i < usf_pkg::NUM_SERVERS; i++) begin
      case (i)
        0:       servers_m[i] = '{mac: 48'h0800_2767_4F20, ip: 32'hC0A8_210A, port: 16'd7073};
        1:       servers_m[i] = '{mac: 48'h9C2D_CD3F_67A4, ip: 32'hC0A8_32E0, port: 16'd8073};
        2:       servers_m[i] = '{mac: 48'h9C2D_CD3F_67A4, ip: 32'hC0A8_32E0, port: 16'd9073};
        3:       servers_m[i] = '{mac: 48'h9C2D_CD48_B104, ip: 32'hC0A8_32D5, port: 16'd10073};
        4:       servers_m[i] = '{mac: 48'h9C2D_CD48_B104, ip: 32'hC0A8_32D5, port: 16'd11073};
        default: servers_m[i] = '0;
      endcase
    end
  endtask

  // Works out what one accepted transaction does: a table write updates the
  // table, a match bumps the counter and fans out, anything else passes.
  task automatic predict_fanout(input hdr_item_t it);
    usf_pkg::res_t r;
    int            i;
    if (it.command == usf_pkg::CMD_TABLE_WRITE) begin
      if (it.entry_index < usf_pkg::NUM_SERVERS) begin
        servers_m[it.entry_index] = '{mac: it.entry_mac, ip: it.entry_ip, port: it.entry_port};
      end
    end else if (it.header_complete && it.ether_type == usf_pkg::ETHERTYPE_IPV4 &&
                 it.ip_protocol == usf_pkg::PROTO_UDP && it.udp_dest_port == seq_port_m) begin
      seq_count_m = seq_count_m + 32'd1;
      for (i = 0; i < usf_pkg::NUM_SERVERS; i++) begin
        r.verdict      = usf_pkg::VERDICT_COPY;
        r.copy_index   = 3'(i);
        r.dest_mac     = servers_m[i].mac;
        r.source_mac   = seq_mac_m;
        r.dest_ip      = servers_m[i].ip;
        r.source_ip    = seq_ip_m;
        r.dest_port    = servers_m[i].port;
        r.ip_checksum  = ipv4_hdr_csum(it.ip_head_words, it.ip_ttl, seq_ip_m, servers_m[i].ip);
        r.sequence_res = seq_count_m;
        r.last_copy    = (i == usf_pkg::NUM_SERVERS - 1);
        expected_copies.push_back(r);
      end
    end else begin
      r           = '0;
      r.verdict   = usf_pkg::VERDICT_PASS;
      r.last_copy = 1'b1;
      expected_copies.push_back(r);
    end
  endtask

  // One line per mismatch, and a count.
  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %0h expected %0h (copy %0d)", name, got, want,
                              copy_index_o));
    end
  endtask

  task automatic check_copy();
    usf_pkg::res_t want;
    if (expected_copies.size() == 0) begin
      flag_mismatch($sformatf("result with nothing expected, verdict %0b copy %0d",
                              verdict_o, copy_index_o));
    end else begin
      want = expected_copies.pop_front();
      check_field("verdict",      64'(verdict_o),      64'(want.verdict));
      check_field("copy_index",   64'(copy_index_o),   64'(want.copy_index));
      check_field("dest_mac",     64'(dest_mac_o),     64'(want.dest_mac));
      check_field("source_mac",   64'(source_mac_o),   64'(want.source_mac));
      check_field("dest_ip",      64'(dest_ip_o),      64'(want.dest_ip));
      check_field("source_ip",    64'(source_ip_o),    64'(want.source_ip));
      check_field("dest_port",    64'(dest_port_o),    64'(want.dest_port));
      check_field("ip_checksum",  64'(ip_checksum_o),  64'(want.ip_checksum));
      check_field("sequence_res", 64'(sequence_res_o), 64'(want.sequence_res));
      check_field("last_copy",    64'(last_copy_o),    64'(want.last_copy));
    end
  endtask

  // Driver: predicts on acceptance, then presents the next queued transaction
  // once the port is free. Random gaps follow some transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_fanout(cur_item);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item           = pending_items.pop_front();
          in_valid_i        <= 1'b1;
          command_i         <= cur_item.command;
          ether_type_i      <= cur_item.ether_type;
          ip_protocol_i     <= cur_item.ip_protocol;
          udp_dest_port_i   <= cur_item.udp_dest_port;
          header_complete_i <= cur_item.header_complete;
          ip_head_words_i   <= cur_item.ip_head_words;
          ip_ttl_i          <= cur_item.ip_ttl;
          entry_index_i     <= cur_item.entry_index;
          entry_port_i      <= cur_item.entry_port;
          entry_ip_i        <= cur_item.entry_ip;
          entry_mac_i       <= cur_item.entry_mac;
          if (idle_en && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and stalls in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_copy();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_en && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 5);
      end
    end
  end

  task automatic push_packet(input logic [15:0] et, input logic [7:0] proto,
                             input logic [15:0] port, input logic complete,
                             input logic [63:0] head, input logic [7:0] ttl);
    hdr_item_t it;
    it                 = '0;
    it.command         = usf_pkg::CMD_PACKET;
    it.ether_type      = et;
    it.ip_protocol     = proto;
    it.udp_dest_port   = port;
    it.header_complete = complete;
    it.ip_head_words   = head;
    it.ip_ttl          = ttl;
    pending_items.push_back(it);
  endtask

  task automatic push_table_write(input logic [2:0] idx, input logic [15:0] port,
                                  input logic [31:0] ip, input logic [47:0] mac);
    hdr_item_t it;
    it             = '0;
    it.command     = usf_pkg::CMD_TABLE_WRITE;
    it.entry_index = idx;
    it.entry_port  = port;
    it.entry_ip    = ip;
    it.entry_mac   = mac;
    pending_items.push_back(it);
  endtask

  // Mostly matching packets with random content; the rest table writes,
  // near misses that break one match condition, and fully random headers.
  function automatic hdr_item_t random_item();
    hdr_item_t it;
    int        pick;
    it.command         = usf_pkg::CMD_PACKET;
    it.ether_type      = usf_pkg::ETHERTYPE_IPV4;
    it.ip_protocol     = usf_pkg::PROTO_UDP;
    it.udp_dest_port   = seq_port_m;
    it.header_complete = 1'b1;
    it.ip_head_words   = rand64();
    it.ip_ttl          = 8'($urandom);
    it.entry_index     = 3'($urandom);
    it.entry_port      = 16'($urandom);
    it.entry_ip        = $urandom;
    it.entry_mac       = 48'(rand64());
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it.command = usf_pkg::CMD_TABLE_WRITE;
    end else if (pick < 27) begin
      case ($urandom_range(0, 3))
        0:       it.header_complete = 1'b0;
        1:       it.ether_type  = usf_pkg::ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15));
        2:       it.ip_protocol = usf_pkg::PROTO_UDP ^ (8'd1 << $urandom_range(0, 7));
        default: it.udp_dest_port = seq_port_m ^ (16'd1 << $urandom_range(0, 15));
      endcase
    end else if (pick < 37) begin
      it.ether_type      = 16'($urandom);
      it.ip_protocol     = 8'($urandom);
      it.udp_dest_port   = 16'($urandom);
      it.header_complete = 1'($urandom);
    end
    return it;
  endfunction

  // Config writes go in only while the block is idle; the shadow copy is
  // updated at the same time, masked to the register width.
  task automatic write_cfg(input usf_pkg::cfg_reg_e idx, input logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      usf_pkg::CFG_SEQ_PORT: seq_port_m = val[15:0];
      usf_pkg::CFG_SEQ_IP:   seq_ip_m   = val[31:0];
      usf_pkg::CFG_SEQ_MAC:  seq_mac_m  = val;
      default:               ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold off until the queue is empty, the port is idle and every expected
  // result is out, then give a trailing table write time to settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_copies.size() != 0);
    repeat (LAT_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int n;
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni  <= 1'b1;
    idle_en  = 1'b1;

    // Directed: reset config and built-in table.
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, usf_pkg::SEQ_PORT_RST, 1'b1,
                64'h0, 8'h00);
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, usf_pkg::SEQ_PORT_RST, 1'b1,
                '1, 8'hff);
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, usf_pkg::SEQ_PORT_RST, 1'b0,
                rand64(), 8'h40);
    push_packet(16'hffff, usf_pkg::PROTO_UDP, usf_pkg::SEQ_PORT_RST, 1'b1, rand64(), 8'h40);
    push_packet(usf_pkg::ETHERTYPE_IPV4, 8'hff, usf_pkg::SEQ_PORT_RST, 1'b1, rand64(), 8'h40);
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, usf_pkg::SEQ_PORT_RST + 16'd1,
                1'b1, rand64(), 8'h40);
    push_packet(16'h0, 8'h0, 16'h0, 1'b0, 64'h0, 8'h0);
    // Table writes at both ends of the range, plus indexes past the table.
    push_table_write(3'd0, '1, '1, '1);
    push_table_write(3'd4, '0, '0, '0);
    push_table_write(3'd7, '1, '1, '1);
    push_table_write(3'd5, 16'h1234, 32'h0a00_0001, 48'h0200_0000_0001);
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, usf_pkg::SEQ_PORT_RST, 1'b1,
                rand64(), 8'h80);
    wait_drained();

    // All-zero settings; junk above the port width must be dropped.
    write_cfg(usf_pkg::CFG_SEQ_PORT, 48'hffff_ffff_0000);
    write_cfg(usf_pkg::CFG_SEQ_IP, 48'h0);
    write_cfg(usf_pkg::CFG_SEQ_MAC, 48'h0);
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, 16'h0, 1'b1, '1, 8'hff);
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, 16'hffff, 1'b1, rand64(), 8'h01);
    wait_drained();

    // All-ones settings.
    write_cfg(usf_pkg::CFG_SEQ_PORT, '1);
    write_cfg(usf_pkg::CFG_SEQ_IP, '1);
    write_cfg(usf_pkg::CFG_SEQ_MAC, '1);
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, 16'hffff, 1'b1, '1, 8'hff);
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, 16'h0, 1'b1, rand64(), 8'h01);
    push_table_write(3'd3, 16'($urandom), $urandom, 48'(rand64()));
    push_packet(usf_pkg::ETHERTYPE_IPV4, usf_pkg::PROTO_UDP, 16'hffff, 1'b1, rand64(),
                8'($urandom));
    wait_drained();

    // Random traffic under random settings; halfway the sender holds off
    // until every expected result is out.
    write_cfg(usf_pkg::CFG_SEQ_PORT, 48'(rand64()));
    write_cfg(usf_pkg::CFG_SEQ_IP, 48'(rand64()));
    write_cfg(usf_pkg::CFG_SEQ_MAC, 48'(rand64()));
    for (n = 0; n < 50; n++) begin
      if (n == 25) wait_drained();
      pending_items.push_back(random_item());
    end
    wait_drained();

    write_cfg(usf_pkg::CFG_SEQ_PORT, 48'(usf_pkg::SEQ_PORT_RST));
    write_cfg(usf_pkg::CFG_SEQ_IP, 48'(rand64()));
    write_cfg(usf_pkg::CFG_SEQ_MAC, 48'(rand64()));
    for (n = 0; n < 30; n++) pending_items.push_back(random_item());
    wait_drained();

    // Closing stretch at full rate on both sides.
    idle_en = 1'b0;
    for (n = 0; n < 20; n++) pending_items.push_back(random_item());
    wait_drained();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
